// ===== sv/jpc_pkg.sv =====
// ----------------------------------------------------------------------------
// jpc_pkg
// Shared types, constants and codes for the joystick pot conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package jpc_pkg;

    // Sample and filter widths
    localparam int unsigned SAMPLE_BITS = 12;
    localparam int unsigned FRAC_BITS   = 8;
    localparam int unsigned AVG_W       = SAMPLE_BITS + FRAC_BITS;
    localparam int unsigned SMAX        = (1 << SAMPLE_BITS) - 1;
    localparam int unsigned ALPHA_W     = 8;
    localparam int unsigned DZ_W        = 11;
    localparam int unsigned HEAD_W      = 9;
    localparam int unsigned CMD_W       = 8;
    localparam int unsigned SW_W        = 2;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 12;

    localparam int unsigned HEADING_SPAN     = 360;
    localparam int unsigned SPEED_SCALE      = 100;
    localparam int unsigned DEBOUNCE_DEFAULT = 3;

    // Shared divider: numerator holds up to 4095 * 360, rounded up to an even width
    localparam int unsigned DIV_NUM_W = 22;
    localparam int unsigned DIV_DEN_W = SAMPLE_BITS;

    // Reset values of the configuration registers and the averages
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET      = ALPHA_W'(51);
    localparam logic [SAMPLE_BITS-1:0] CENTER_RESET    = SAMPLE_BITS'(2048);
    localparam logic [DZ_W-1:0]       DEADZONE_RESET   = DZ_W'(700);
    localparam logic [SAMPLE_BITS-1:0] JITTER_RESET    = SAMPLE_BITS'(20);
    localparam logic [SAMPLE_BITS-1:0] LEFT_BELOW_RESET  = SAMPLE_BITS'(1300);
    localparam logic [SAMPLE_BITS-1:0] MID_ABOVE_RESET   = SAMPLE_BITS'(1700);
    localparam logic [SAMPLE_BITS-1:0] MID_BELOW_RESET   = SAMPLE_BITS'(2800);
    localparam logic [SAMPLE_BITS-1:0] RIGHT_ABOVE_RESET = SAMPLE_BITS'(3200);
    localparam logic [AVG_W-1:0]      AVG_RESET =
        AVG_W'((1 << (SAMPLE_BITS - 1)) << FRAC_BITS);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA          = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CENTER       = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_DEADZONE     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_THRESHOLD   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_LEFT_BELOW  = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MID_ABOVE   = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_MID_BELOW   = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_RIGHT_ABOVE = CFG_IDX_W'(7);

    // Switch position codes
    localparam logic [SW_W-1:0] POS_LEFT  = SW_W'(0);
    localparam logic [SW_W-1:0] POS_MID   = SW_W'(1);
    localparam logic [SW_W-1:0] POS_RIGHT = SW_W'(2);

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] rudder_sample;
        logic [SAMPLE_BITS-1:0] throttle_sample;
        logic [SAMPLE_BITS-1:0] switch_sample;
    } sample_t;

    typedef struct packed {
        logic [HEAD_W-1:0]        heading_deg;
        logic signed [CMD_W-1:0]  speed_cmd;
        logic                     speed_updated;
        logic [SAMPLE_BITS-1:0]   speed_level;
        logic [SW_W-1:0]          switch_position;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILTER,
        ST_HEAD,
        ST_HEAD_WAIT,
        ST_SPEED,
        ST_SPEED_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic filter;
        logic head_start;
        logic head_cap;
        logic speed_start;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic speed_band;
        logic out_free;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== sv/jpc_div.sv =====
// ----------------------------------------------------------------------------
// jpc_div
// Sequential unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jpc_div #(
    parameter int unsigned NUM_W = 22,
    parameter int unsigned DEN_W = 12
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int unsigned STEPS = NUM_W / 2;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic [NUM_W-1:0] work_reg, work_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    // Two dependent restoring steps; quotient bits shift into the low end
    always_comb
    begin
        logic [DEN_W:0] trial;
        logic [NUM_W-1:0] w;
        logic [DEN_W:0] r;
        w = work_reg;
        r = rem_reg;
        for (int i = 0; i < 2; i++)
        begin
            trial = {r[DEN_W-1:0], w[NUM_W-1]};
            w = {w[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                r = trial - {1'b0, den_reg};
                w[0] = 1'b1;
            end
            else
            begin
                r = trial;
            end
        end
        work_next = w;
        rem_next  = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= num;
            den_reg  <= den;
            rem_reg  <= '0;
        end
        else if (cnt_reg != '0)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

`default_nettype wire

// ===== sv/jpc_datapath.sv =====
// ----------------------------------------------------------------------------
// jpc_datapath
// Configuration registers, EMA filters, switch debounce, heading and speed
// maps on the shared divider, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module jpc_datapath #(
    parameter int unsigned DEBOUNCE_COUNT = jpc_pkg::DEBOUNCE_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [jpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [jpc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire jpc_pkg::sample_t                    sample,
    input  wire jpc_pkg::ctrl_cmd_t                  cmd,
    output jpc_pkg::ctrl_status_t                    status,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output jpc_pkg::result_t                         result
);

    import jpc_pkg::*;

    localparam int unsigned RUN_W = $clog2(DEBOUNCE_COUNT + 2);
    localparam int unsigned CMP_W = SAMPLE_BITS + 2;

    // Configuration
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [SAMPLE_BITS-1:0] center_reg;
    logic [DZ_W-1:0]        deadzone_reg;
    logic [SAMPLE_BITS-1:0] jitter_reg;
    logic [SAMPLE_BITS-1:0] left_below_reg;
    logic [SAMPLE_BITS-1:0] mid_above_reg;
    logic [SAMPLE_BITS-1:0] mid_below_reg;
    logic [SAMPLE_BITS-1:0] right_above_reg;

    // Item state
    sample_t                smp_reg;
    logic [AVG_W-1:0]       rudder_avg_reg;
    logic [AVG_W-1:0]       throttle_avg_reg;
    logic [SAMPLE_BITS-1:0] reported_reg;
    logic [CMD_W-1:0]       held_speed_reg;
    logic [SW_W-1:0]        switch_pos_reg;
    logic [RUN_W-1:0]       run_reg;
    logic [HEAD_W-1:0]      heading_reg;
    logic                   speed_neg_reg;
    logic                   speed_band_reg;
    logic                   result_valid_reg;
    result_t                result_reg;

    logic [SAMPLE_BITS-1:0]   rv;
    logic [SAMPLE_BITS-1:0]   val;
    logic signed [CMP_W-1:0]  low;
    logic signed [CMP_W-1:0]  high;
    logic signed [CMP_W-1:0]  val_s;
    logic signed [CMP_W-1:0]  above_high;
    logic signed [CMP_W-1:0]  top_span;
    logic                     val_lt_low;
    logic                     val_gt_high;
    logic                     band;
    logic                     div_start;
    logic [DIV_NUM_W-1:0]     div_num;
    logic [DIV_DEN_W-1:0]     div_den;
    logic                     div_done;
    logic [DIV_NUM_W-1:0]     div_quot;
    logic [DIV_NUM_W-1:0]     head_num;
    logic [DIV_NUM_W-1:0]     speed_num;
    logic [DIV_DEN_W-1:0]     speed_den;
    logic [SW_W-1:0]          cand;
    logic [RUN_W-1:0]         run_inc;
    logic [SW_W-1:0]          switch_pos_next;
    logic [RUN_W-1:0]         run_next;
    logic [CMD_W-1:0]         speed_q;
    logic [CMD_W-1:0]         speed_new;
    logic [SAMPLE_BITS-1:0]   level_gap;
    logic                     move;
    logic                     out_free;

    function automatic logic [AVG_W-1:0] ema_next(
        input logic [AVG_W-1:0]       avg,
        input logic [SAMPLE_BITS-1:0] x,
        input logic [ALPHA_W-1:0]     a
    );
        logic signed [AVG_W:0]                   diff;
        logic signed [AVG_W+ALPHA_W:0]           prod;
        logic signed [AVG_W+ALPHA_W-FRAC_BITS:0] step;
        logic signed [AVG_W+1:0]                 sum;
        diff = $signed({1'b0, x, {FRAC_BITS{1'b0}}}) - $signed({1'b0, avg});
        prod = diff * $signed({1'b0, a});
        // floor division by 256: keep the high bits of the signed product
        step = prod[AVG_W+ALPHA_W:FRAC_BITS];
        sum  = $signed({2'b00, avg}) + step;
        return sum[AVG_W-1:0];
    endfunction

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg       <= ALPHA_RESET;
            center_reg      <= CENTER_RESET;
            deadzone_reg    <= DEADZONE_RESET;
            jitter_reg      <= JITTER_RESET;
            left_below_reg  <= LEFT_BELOW_RESET;
            mid_above_reg   <= MID_ABOVE_RESET;
            mid_below_reg   <= MID_BELOW_RESET;
            right_above_reg <= RIGHT_ABOVE_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_EMA_ALPHA:          alpha_reg       <= cfg_data[ALPHA_W-1:0];
                REG_SPEED_CENTER:       center_reg      <= cfg_data[SAMPLE_BITS-1:0];
                REG_SPEED_DEADZONE:     deadzone_reg    <= cfg_data[DZ_W-1:0];
                REG_JITTER_THRESHOLD:   jitter_reg      <= cfg_data[SAMPLE_BITS-1:0];
                REG_SWITCH_LEFT_BELOW:  left_below_reg  <= cfg_data[SAMPLE_BITS-1:0];
                REG_SWITCH_MID_ABOVE:   mid_above_reg   <= cfg_data[SAMPLE_BITS-1:0];
                REG_SWITCH_MID_BELOW:   mid_below_reg   <= cfg_data[SAMPLE_BITS-1:0];
                REG_SWITCH_RIGHT_ABOVE: right_above_reg <= cfg_data[SAMPLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Switch classification; gap zones keep the shown position
    always_comb
    begin
        cand = switch_pos_reg;
        if (smp_reg.switch_sample < left_below_reg)
        begin
            cand = POS_LEFT;
        end
        else if (smp_reg.switch_sample > mid_above_reg
                 && smp_reg.switch_sample < mid_below_reg)
        begin
            cand = POS_MID;
        end
        else if (smp_reg.switch_sample > right_above_reg)
        begin
            cand = POS_RIGHT;
        end

        run_inc         = run_reg + RUN_W'(1);
        switch_pos_next = switch_pos_reg;
        run_next        = '0;
        if (cand != switch_pos_reg)
        begin
            if (run_inc > RUN_W'(DEBOUNCE_COUNT))
            begin
                switch_pos_next = cand;
            end
            else
            begin
                run_next = run_inc;
            end
        end
    end

    // Speed map selection
    assign rv    = rudder_avg_reg[AVG_W-1:FRAC_BITS];
    assign val   = throttle_avg_reg[AVG_W-1:FRAC_BITS];
    assign val_s = $signed({2'b00, val});
    assign low   = $signed({2'b00, center_reg}) - $signed({3'b000, deadzone_reg});
    assign high  = $signed({2'b00, center_reg}) + $signed({3'b000, deadzone_reg});
    assign above_high  = val_s - high;
    assign top_span    = $signed(CMP_W'(SMAX)) - high;
    assign val_lt_low  = val_s < low;
    assign val_gt_high = val_s > high;
    assign band        = !val_lt_low && !val_gt_high;

    assign head_num  = DIV_NUM_W'(rv) * DIV_NUM_W'(HEADING_SPAN);
    assign speed_num = val_lt_low ? DIV_NUM_W'(val) * DIV_NUM_W'(SPEED_SCALE)
                                  : DIV_NUM_W'(above_high[SAMPLE_BITS-1:0])
                                    * DIV_NUM_W'(SPEED_SCALE);
    assign speed_den = val_lt_low ? low[DIV_DEN_W-1:0] : top_span[DIV_DEN_W-1:0];

    assign div_start = cmd.head_start || (cmd.speed_start && !band);
    assign div_num   = cmd.head_start ? head_num : speed_num;
    assign div_den   = cmd.head_start ? DIV_DEN_W'(SMAX) : speed_den;

    jpc_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Commit: speed command and jitter gate
    assign speed_q   = {1'b0, div_quot[CMD_W-2:0]};
    assign speed_new = speed_band_reg ? '0
                     : (speed_neg_reg ? speed_q - CMD_W'(SPEED_SCALE) : speed_q);
    assign level_gap = (reported_reg >= val) ? reported_reg - val : val - reported_reg;
    assign move      = level_gap > jitter_reg;
    assign out_free  = !result_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rudder_avg_reg   <= AVG_RESET;
            throttle_avg_reg <= AVG_RESET;
            reported_reg     <= '0;
            held_speed_reg   <= '0;
            switch_pos_reg   <= POS_MID;
            run_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.filter)
            begin
                rudder_avg_reg   <= ema_next(rudder_avg_reg, smp_reg.rudder_sample, alpha_reg);
                throttle_avg_reg <= ema_next(throttle_avg_reg, smp_reg.throttle_sample,
                                             alpha_reg);
                switch_pos_reg   <= switch_pos_next;
                run_reg          <= run_next;
            end
            if (cmd.commit && move)
            begin
                reported_reg   <= val;
                held_speed_reg <= speed_new;
            end
            if (cmd.commit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_reg <= sample;
        end
        if (cmd.head_cap)
        begin
            heading_reg <= HEAD_W'(HEADING_SPAN) - div_quot[HEAD_W-1:0];
        end
        if (cmd.speed_start)
        begin
            speed_neg_reg  <= val_lt_low;
            speed_band_reg <= band;
        end
        if (cmd.commit)
        begin
            result_reg.heading_deg     <= heading_reg;
            result_reg.speed_cmd       <= $signed(move ? speed_new : held_speed_reg);
            result_reg.speed_updated   <= move;
            result_reg.speed_level     <= move ? val : reported_reg;
            result_reg.switch_position <= switch_pos_reg;
        end
    end

    assign status.div_done   = div_done;
    assign status.speed_band = band;
    assign status.out_free   = out_free;
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= RUN_W'(DEBOUNCE_COUNT))
        else $error("debounce run count passed its limit");

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid_reg)
        else $error("committed result not presented");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.head_cap) |-> heading_reg <= HEAD_W'(HEADING_SPAN))
        else $error("heading out of range");

endmodule

`default_nettype wire

// ===== sv/jpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// jpc_ctrl
// Sequencer: accept, filter, heading divide, speed divide, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module jpc_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  sample_valid,
    output logic                       sample_stall,
    input  wire jpc_pkg::ctrl_status_t status,
    output jpc_pkg::ctrl_cmd_t         cmd
);

    import jpc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_FILTER;
                end
            end
            ST_FILTER:
            begin
                cmd.filter = 1'b1;
                state_next = ST_HEAD;
            end
            ST_HEAD:
            begin
                cmd.head_start = 1'b1;
                state_next     = ST_HEAD_WAIT;
            end
            ST_HEAD_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.head_cap = 1'b1;
                    state_next   = ST_SPEED;
                end
            end
            ST_SPEED:
            begin
                cmd.speed_start = 1'b1;
                // skip the divide inside the zero band
                state_next = status.speed_band ? ST_FINISH : ST_SPEED_WAIT;
            end
            ST_SPEED_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the result register can take the request
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == ST_HEAD_WAIT || state_reg == ST_SPEED_WAIT))
        else $error("divider finished outside a wait state");

    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free)
        else $error("commit while result register is full");

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !status.out_free) |=> state_reg == ST_FINISH)
        else $error("left finish while output blocked");

endmodule

`default_nettype wire

// ===== sv/joystick_pot_conditioner_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_pot_conditioner_unit
// Conditions rudder pot, speed pot and mode switch samples into heading,
// speed command and debounced switch position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel sample/sample_valid/sample_stall carries one reading of all
//   three converters. A request is taken when sample_valid is high and
//   sample_stall is low; sample_stall is low only while the block is idle.
//   Output channel result/result_valid/result_stall returns one result per
//   request, held in an output register until the receiver drops result_stall.
//   Each item steps through accept, filter, heading divide, speed divide
//   and commit. Each divide on the shared divider holds the sequencer
//   through start, 11 steps at two quotient bits per cycle, and done, once
//   for heading and once for speed; when the filtered throttle sits inside
//   the zero band, the wait on the speed divide is skipped.
//   A stalled receiver holds the finished item in the sequencer's last step;
//   the next request is taken once that item reaches the output register.
//   Configuration writes (cfg_write_en, cfg_index, cfg_data) take effect at
//   once and must only be issued while the block is idle.
//   Reset loads the default configuration, sets both averages to mid scale,
//   the switch to middle, the reported speed level and command to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_pot_conditioner_unit #(
    parameter int unsigned DEBOUNCE_COUNT = jpc_pkg::DEBOUNCE_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write_en,
    input  wire logic [jpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [jpc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           sample_valid,
    output logic                                sample_stall,
    input  wire jpc_pkg::sample_t               sample,
    output logic                                result_valid,
    input  wire logic                           result_stall,
    output jpc_pkg::result_t                    result
);

    import jpc_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    jpc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .status       (status),
        .cmd          (cmd)
    );

    jpc_datapath #(
        .DEBOUNCE_COUNT (DEBOUNCE_COUNT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
